// ===== rtl/crcfr_pkg.sv =====
`default_nettype none
package crcfr_pkg;

	localparam int unsigned BUFFER_DEPTH = 256;
	localparam int unsigned FILL_W       = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned PAYLOAD_CAP  = 64;
	localparam int unsigned PAY_AW       = $clog2(PAYLOAD_CAP);
	localparam int unsigned LEN_W        = $clog2(PAYLOAD_CAP + 1);
	localparam int unsigned BANKS        = 2;
	localparam int unsigned MEM_AW       = PAY_AW + $clog2(BANKS);
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned HELD_W       = $clog2(BANKS + 1);

	localparam logic [7:0] START_MARK = 8'hAA;
	localparam logic [7:0] END_MARK   = 8'h55;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam int unsigned MIN_FRAME = 6;
	// frame layout: start, type, length high, length low, payload...
	localparam int unsigned IDX_TYPE  = 1;
	localparam int unsigned IDX_LEN_H = 2;
	localparam int unsigned IDX_LEN_L = 3;
	localparam int unsigned IDX_PAY   = 4;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	typedef struct packed {
		logic [$clog2(BANKS)-1:0] bank;
		logic [7:0]               cmd_type;
		logic [LEN_W-1:0]         len;
	} desc_t;

	// CRC-8, MSB first, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/crcfr_if.sv =====
`default_nettype none
interface crcfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfr_res_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  cmd_type;
	logic [7:0]                  payload_byte;
	logic [crcfr_pkg::LEN_W-1:0] payload_length;
	logic                        empty_payload;
	logic                        last_of_frame;

	modport source (output valid, output cmd_type, output payload_byte,
		output payload_length, output empty_payload, output last_of_frame, input ready);
	modport sink (input valid, input cmd_type, input payload_byte,
		input payload_length, input empty_payload, input last_of_frame, output ready);
endinterface
`default_nettype wire

// ===== rtl/crcfr_front.sv =====
`default_nettype none
module crcfr_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	crcfr_rx_if.sink                 rx,
	input  wire logic                cfg_we,
	input  wire logic [6:0]          cfg_data,
	input  wire logic                bank_free,
	output crcfr_pkg::mem_wr_t       mem_wr,
	output logic                     q_push,
	output crcfr_pkg::desc_t         q_desc
);

	logic [crcfr_pkg::FILL_W-1:0]        fill_q;
	logic [crcfr_pkg::HELD_W-1:0]        held_q;
	logic [$clog2(crcfr_pkg::BANKS)-1:0] bank_q;
	logic [6:0]                          max_payload_q;
	logic [7:0]                          crc_q;
	logic [7:0]                          snap_q;
	logic [7:0]                          prev_q;
	logic [7:0]                          type_q;
	logic                                hi_nz_q;
	logic                                big_q;
	logic [crcfr_pkg::LEN_W-1:0]         len_q;

	logic                                acc;
	logic [7:0]                          b;
	logic [crcfr_pkg::FILL_W-1:0]        k;
	logic [crcfr_pkg::FILL_W-1:0]        k_inc;
	logic [crcfr_pkg::FILL_W-1:0]        off;
	logic                                store;
	logic                                is_end;
	logic                                snap;
	logic                                good;
	logic [7:0]                          crc_new;
	logic [6:0]                          limit;

	assign rx.ready = (held_q != crcfr_pkg::HELD_W'(crcfr_pkg::BANKS));
	assign acc      = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign k        = fill_q;
	assign k_inc    = k + crcfr_pkg::FILL_W'(1);
	assign off      = k - crcfr_pkg::FILL_W'(crcfr_pkg::IDX_PAY);
	assign crc_new  = crcfr_pkg::crc8_update(crc_q, b);
	assign limit    = (max_payload_q > 7'(crcfr_pkg::PAYLOAD_CAP)) ?
		7'(crcfr_pkg::PAYLOAD_CAP) : max_payload_q;

	always_comb begin
		store  = acc && ((k != '0) || (b == crcfr_pkg::START_MARK));
		is_end = store && (b == crcfr_pkg::END_MARK) &&
			(k >= crcfr_pkg::FILL_W'(crcfr_pkg::MIN_FRAME - 1));
		// latch the CRC once the last payload byte (or the length, if empty) is in
		snap = store && (
			((k == crcfr_pkg::FILL_W'(crcfr_pkg::IDX_LEN_L)) && !hi_nz_q && (b == 8'h00)) ||
			((k > crcfr_pkg::FILL_W'(crcfr_pkg::IDX_LEN_L)) && !big_q &&
			 (k == crcfr_pkg::FILL_W'(len_q) + crcfr_pkg::FILL_W'(crcfr_pkg::IDX_LEN_L))));
		good = is_end && !big_q && (7'(len_q) <= limit) &&
			(k >= crcfr_pkg::FILL_W'(len_q) + crcfr_pkg::FILL_W'(crcfr_pkg::MIN_FRAME - 1)) &&
			(snap_q == prev_q);
	end

	always_comb begin
		mem_wr.en   = store && (k >= crcfr_pkg::FILL_W'(crcfr_pkg::IDX_PAY)) &&
			(k < crcfr_pkg::FILL_W'(crcfr_pkg::IDX_PAY + crcfr_pkg::PAYLOAD_CAP));
		mem_wr.addr = {bank_q, off[crcfr_pkg::PAY_AW-1:0]};
		mem_wr.data = b;
	end

	assign q_push          = good;
	assign q_desc.bank     = bank_q;
	assign q_desc.cmd_type = type_q;
	assign q_desc.len      = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			held_q        <= '0;
			bank_q        <= '0;
			max_payload_q <= 7'(crcfr_pkg::PAYLOAD_CAP);
		end else begin
			if (cfg_we) begin
				max_payload_q <= cfg_data;
			end
			if (store) begin
				if (is_end || (k_inc == crcfr_pkg::FILL_W'(crcfr_pkg::BUFFER_DEPTH))) begin
					fill_q <= '0;
				end else begin
					fill_q <= k_inc;
				end
			end
			if (good) begin
				bank_q <= bank_q + 1'b1;
			end
			held_q <= held_q + crcfr_pkg::HELD_W'(good) - crcfr_pkg::HELD_W'(bank_free);
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			prev_q <= b;
			crc_q  <= (k == '0) ? 8'h00 : crc_new;
			if (snap) begin
				snap_q <= crc_new;
			end
			if (k == crcfr_pkg::FILL_W'(crcfr_pkg::IDX_TYPE)) begin
				type_q <= b;
			end
			if (k == crcfr_pkg::FILL_W'(crcfr_pkg::IDX_LEN_H)) begin
				hi_nz_q <= (b != 8'h00);
			end
			if (k == crcfr_pkg::FILL_W'(crcfr_pkg::IDX_LEN_L)) begin
				big_q <= hi_nz_q || (b > 8'(crcfr_pkg::PAYLOAD_CAP));
				len_q <= b[crcfr_pkg::LEN_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/crcfr_fifo.sv =====
`default_nettype none
module crcfr_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  crcfr_pkg::desc_t      push_desc,
	input  wire logic             pop,
	output crcfr_pkg::desc_t      head,
	output logic                  empty,
	output logic                  full
);

	crcfr_pkg::desc_t                entry_q [crcfr_pkg::QUEUE_DEPTH];
	logic [crcfr_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [crcfr_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [crcfr_pkg::QCNT_W-1:0]    count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == crcfr_pkg::QCNT_W'(crcfr_pkg::QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + crcfr_pkg::QCNT_W'(push && !full)
				- crcfr_pkg::QCNT_W'(pop && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/crcfr_back.sv =====
`default_nettype none
module crcfr_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  crcfr_pkg::mem_wr_t    mem_wr,
	input  wire logic             q_empty,
	input  crcfr_pkg::desc_t      q_head,
	output logic                  q_pop,
	output logic                  bank_free,
	crcfr_res_if.source           res
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SHOW = 2'b10
	} back_state_t;

	back_state_t                     state_q;
	crcfr_pkg::desc_t                desc_q;
	logic [crcfr_pkg::PAY_AW-1:0]    idx_q;
	logic [crcfr_pkg::PAY_AW-1:0]    idx_d;
	logic [7:0]                      mem [crcfr_pkg::BANKS * crcfr_pkg::PAYLOAD_CAP];
	logic [7:0]                      rd_data_q;
	logic [crcfr_pkg::MEM_AW-1:0]    rd_addr;
	logic                            empty_frame;
	logic                            last;
	logic                            beat;

	assign empty_frame = (desc_q.len == '0);
	assign last        = empty_frame ||
		((crcfr_pkg::LEN_W'(idx_q) + crcfr_pkg::LEN_W'(1)) == desc_q.len);
	assign beat        = (state_q == S_SHOW) && res.ready;
	assign q_pop       = (state_q == S_IDLE) && !q_empty;
	assign bank_free   = beat && last;

	always_comb begin
		idx_d   = idx_q;
		rd_addr = {desc_q.bank, idx_q};
		unique case (state_q)
			S_IDLE: begin
				idx_d   = '0;
				rd_addr = {q_head.bank, {crcfr_pkg::PAY_AW{1'b0}}};
			end
			S_SHOW: begin
				if (beat && !last) begin
					idx_d = idx_q + crcfr_pkg::PAY_AW'(1);
				end
				rd_addr = {desc_q.bank, idx_d};
			end
			default: begin
				idx_d   = '0;
				rd_addr = {desc_q.bank, idx_q};
			end
		endcase
	end

	// payload memory: front writes the free bank, read data is registered
	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem[mem_wr.addr] <= mem_wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			idx_q <= idx_d;
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_SHOW;
					end
				end
				S_SHOW: begin
					if (beat && last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q <= q_head;
		end
	end

	assign res.valid          = (state_q == S_SHOW);
	assign res.cmd_type       = desc_q.cmd_type;
	assign res.payload_byte   = empty_frame ? 8'h00 : rd_data_q;
	assign res.payload_length = desc_q.len;
	assign res.empty_payload  = empty_frame;
	assign res.last_of_frame  = last;

endmodule
`default_nettype wire

// ===== rtl/crc8_frame_receiver.sv =====
// channel  | dir | beat carries
// rx       | in  | rx_byte
// res      | out | cmd_type, payload_byte, payload_length, empty_payload, last_of_frame
// cfg      | in  | max_payload (cfg_we, cfg_data)
//
// Front takes one byte per cycle while rx.ready is high: framing, running CRC-8 and the check all settle in that cycle.
// Payload goes to a two-bank memory; a good frame queues a descriptor for the back end.
// Back end opens a frame from its idle state, then gives one result per cycle while res is ready (one memory read).
// rx stalls only while both banks hold frames not yet fully drained.
// Reset clears the fill index, the queue and the bank counts; max_payload returns to 64.
`default_nettype none
module crc8_frame_receiver (
	input  wire logic       clk,
	input  wire logic       arst_n,
	crcfr_rx_if.sink        rx,
	crcfr_res_if.source     res,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_data
);

	crcfr_pkg::mem_wr_t mem_wr;
	crcfr_pkg::desc_t   push_desc;
	crcfr_pkg::desc_t   head;
	logic               q_push;
	logic               q_pop;
	logic               q_empty;
	logic               q_full;
	logic               bank_free;

	crcfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.bank_free (bank_free),
		.mem_wr    (mem_wr),
		.q_push    (q_push),
		.q_desc    (push_desc)
	);

	crcfr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.pop       (q_pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	crcfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_wr    (mem_wr),
		.q_empty   (q_empty),
		.q_head    (head),
		.q_pop     (q_pop),
		.bank_free (bank_free),
		.res       (res)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("descriptor pushed into full queue");

	a_push_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (rx.valid && rx.ready))
		else $error("descriptor pushed without an rx beat");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && res.last_of_frame) |=> !res.valid)
		else $error("result shown right after last beat of a frame");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.empty_payload) |-> (res.last_of_frame && res.payload_length == '0))
		else $error("empty-frame result not marked last");

endmodule
`default_nettype wire

// ===== tb/tb_crc8_frame_receiver.sv =====
`timescale 1ns / 1ps

module tb_crc8_frame_receiver;

	localparam int SETTLE = 12;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [7:0]                  cmd_type;
		logic [7:0]                  payload_byte;
		logic [crcfr_pkg::LEN_W-1:0] payload_length;
		logic                        empty_payload;
		logic                        last_of_frame;
	} frame_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_data;

	crcfr_rx_if  rx_ch();
	crcfr_res_if res_ch();

	crc8_frame_receiver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// deframer shadow state
	logic [7:0]    frame_buf [crcfr_pkg::BUFFER_DEPTH];
	int unsigned   frame_fill;
	logic [6:0]    max_payload_cfg;
	frame_result_t awaited_payload[$];

	int mismatches;
	int beats_sent;
	bit quiet;
	int long_stall_req;
	int res_stall_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) c = c[7] ? ((c << 1) ^ crcfr_pkg::CRC_POLY) : (c << 1);
		return c;
	endfunction

	function automatic int cur_limit();
		return (max_payload_cfg > crcfr_pkg::PAYLOAD_CAP) ? crcfr_pkg::PAYLOAD_CAP
			: max_payload_cfg;
	endfunction

	// advance the shadow deframer by one accepted byte
	function automatic void deframe_byte(logic [7:0] b);
		int unsigned   flen;
		logic [7:0]    crc;
		logic [7:0]    ftype;
		frame_result_t r;
		if (frame_fill >= crcfr_pkg::BUFFER_DEPTH) frame_fill = 0;
		if (frame_fill == 0 && b != crcfr_pkg::START_MARK) return;
		frame_buf[frame_fill] = b;
		frame_fill++;
		if (b == crcfr_pkg::END_MARK && frame_fill >= crcfr_pkg::MIN_FRAME) begin
			ftype = frame_buf[crcfr_pkg::IDX_TYPE];
			flen  = {frame_buf[crcfr_pkg::IDX_LEN_H], frame_buf[crcfr_pkg::IDX_LEN_L]};
			if (flen <= cur_limit() && frame_fill >= flen + crcfr_pkg::MIN_FRAME) begin
				crc = 8'h00;
				for (int i = crcfr_pkg::IDX_TYPE; i < crcfr_pkg::IDX_PAY + flen; i++)
					crc = crc8_step(crc, frame_buf[i]);
				if (crc == frame_buf[frame_fill - 2]) begin
					if (flen == 0) begin
						r = '{ftype, 8'h00, '0, 1'b1, 1'b1};
						awaited_payload.push_back(r);
					end else begin
						for (int i = 0; i < flen; i++) begin
							r = '{ftype, frame_buf[crcfr_pkg::IDX_PAY + i],
								flen[crcfr_pkg::LEN_W-1:0], 1'b0, (i + 1 == flen)};
							awaited_payload.push_back(r);
						end
					end
				end
			end
			frame_fill = 0;
		end
		if (frame_fill >= crcfr_pkg::BUFFER_DEPTH) frame_fill = 0;
	endfunction

	function automatic void note_mismatch(string what, frame_result_t exp, frame_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: exp type %h byte %h len %0d empty %b last %b", what,
				exp.cmd_type, exp.payload_byte, exp.payload_length, exp.empty_payload,
				exp.last_of_frame,
				"  got type %h byte %h len %0d empty %b last %b",
				got.cmd_type, got.payload_byte, got.payload_length, got.empty_payload,
				got.last_of_frame);
	endfunction

	// result sink: random stalls, plus long stalls on request
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t exp;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.cmd_type, res_ch.payload_byte, res_ch.payload_length,
					res_ch.empty_payload, res_ch.last_of_frame};
				if (awaited_payload.size() == 0) begin
					note_mismatch("unexpected beat", got, got);
				end else begin
					exp = awaited_payload.pop_front();
					if (got.cmd_type !== exp.cmd_type || got.payload_byte !== exp.payload_byte ||
						got.payload_length !== exp.payload_length ||
						got.empty_payload !== exp.empty_payload ||
						got.last_of_frame !== exp.last_of_frame)
						note_mismatch("result mismatch", exp, got);
				end
			end
			if (long_stall_req > 0) begin
				res_stall_left = long_stall_req;
				long_stall_req = 0;
			end
			if (res_stall_left > 0) begin
				res_stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (!quiet) res_stall_left = pick_gap();
			end
		end
	end

	task automatic send_beat(input logic [7:0] b);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		deframe_byte(b);
		beats_sent++;
	endtask

	task automatic wait_drained();
		rx_ch.valid <= 1'b0;
		while (awaited_payload.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_max_payload(input logic [6:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		max_payload_cfg = v;
	endtask

	function automatic logic [7:0] pick_payload(bit allow_end);
		logic [7:0] v;
		do v = $urandom_range(0, 255); while (!allow_end && v == crcfr_pkg::END_MARK);
		return v;
	endfunction

	function automatic byte_q_t make_body(int n, bit allow_end);
		byte_q_t q;
		repeat (n) q.push_back(pick_payload(allow_end));
		return q;
	endfunction

	task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
		input byte_q_t body, input int extra, input bit corrupt);
		logic [7:0] crc;
		crc = crc8_step(crc8_step(crc8_step(8'h00, ftype), flen[15:8]), flen[7:0]);
		foreach (body[i]) crc = crc8_step(crc, body[i]);
		if (corrupt) crc ^= 8'($urandom_range(1, 255));
		send_beat(crcfr_pkg::START_MARK);
		send_beat(ftype);
		send_beat(flen[15:8]);
		send_beat(flen[7:0]);
		foreach (body[i]) send_beat(body[i]);
		repeat (extra) send_beat(pick_payload(1'b0));
		send_beat(crc);
		send_beat(crcfr_pkg::END_MARK);
	endtask

	// close any partial frame so the next start byte opens a fresh one
	task automatic flush_frame();
		while (frame_fill != 0)
			send_beat(frame_fill >= crcfr_pkg::MIN_FRAME - 1 ? crcfr_pkg::END_MARK : 8'h00);
	endtask

	task automatic test_default_limit();
		send_frame(8'h5A, 16'd64, make_body(64, 1'b0), 0, 1'b0);
	endtask

	task automatic test_empty_payload();
		byte_q_t none;
		send_frame(8'hFF, 16'd0, none, 0, 1'b0);
		send_frame(8'h00, 16'd0, none, 0, 1'b0);
	endtask

	task automatic test_field_extremes();
		byte_q_t q;
		q = {8'h00};
		send_frame(8'h00, 16'd1, q, 0, 1'b0);
		q = {8'hFF, 8'h00, 8'hFF};
		send_frame(8'hFF, 16'd3, q, 0, 1'b0);
		// first payload byte may be the end mark: too few bytes stored to close
		q = {8'h55, 8'h01};
		send_frame(8'h55, 16'd2, q, 0, 1'b0);
		q = {8'hAA};
		send_frame(8'hAA, 16'd1, q, 0, 1'b0);
	endtask

	task automatic test_bad_frames();
		byte_q_t q;
		send_frame(8'h11, 16'd3, make_body(3, 1'b0), 0, 1'b1);
		send_frame(8'h22, 16'h0102, make_body(2, 1'b0), 0, 1'b0);
		send_frame(8'h33, 16'd6, make_body(3, 1'b0), 0, 1'b0);
		flush_frame();
		// end mark inside payload closes the frame early
		q = {8'h10, 8'h55, 8'h20, 8'h30};
		send_frame(8'h44, 16'd4, q, 0, 1'b0);
		flush_frame();
		// extra bytes before the check byte are tolerated
		send_frame(8'h66, 16'd2, make_body(2, 1'b0), 3, 1'b0);
		// end mark with fewer than six bytes stored is just data
		send_beat(crcfr_pkg::START_MARK);
		send_beat(8'h01);
		send_beat(crcfr_pkg::END_MARK);
		flush_frame();
	endtask

	task automatic test_noise();
		logic [7:0] v;
		repeat (20) begin
			do v = $urandom_range(0, 255); while (v == crcfr_pkg::START_MARK);
			send_beat(v);
		end
		send_beat(8'h00);
		send_beat(8'hFF);
		send_beat(crcfr_pkg::END_MARK);
		send_frame(8'h77, 16'd2, make_body(2, 1'b0), 0, 1'b0);
	endtask

	task automatic test_overflow();
		logic [7:0] v;
		send_beat(crcfr_pkg::START_MARK);
		repeat (crcfr_pkg::BUFFER_DEPTH + 6) begin
			do v = $urandom_range(0, 255);
			while (v == crcfr_pkg::END_MARK || v == crcfr_pkg::START_MARK);
			send_beat(v);
		end
		send_frame(8'h88, 16'd3, make_body(3, 1'b0), 0, 1'b0);
		flush_frame();
	endtask

	task automatic test_limit_settings();
		int lims[3] = '{0, 1, 127};
		int lim;
		byte_q_t none;
		foreach (lims[k]) begin
			flush_frame();
			wait_drained();
			set_max_payload(7'(lims[k]));
			lim = cur_limit();
			send_frame(8'($urandom), 16'(lim), make_body(lim, 1'b0), 0, 1'b0);
			send_frame(8'($urandom), 16'(lim + 1), make_body(lim + 1, 1'b0), 0, 1'b0);
			send_frame(8'($urandom), 16'd0, none, 0, 1'b0);
		end
		wait_drained();
		set_max_payload(7'd64);
	endtask

	task automatic test_backpressure();
		long_stall_req = 300;
		repeat (6) send_frame(8'($urandom), 16'd4, make_body(4, 1'b0), 0, 1'b0);
		// hold the sender until the back end has emptied
		wait_drained();
		quiet = 1'b1;
		repeat (4) send_frame(8'($urandom), 16'd3, make_body(3, 1'b0), 0, 1'b0);
		quiet = 1'b0;
		wait_drained();
	endtask

	task automatic test_random();
		int stop_at;
		int r;
		int lim;
		int flen;
		bit reconfigured;
		stop_at = beats_sent + 150;
		reconfigured = 1'b0;
		while (beats_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) quiet = !quiet;
			if (!reconfigured && beats_sent > stop_at - 75) begin
				reconfigured = 1'b1;
				flush_frame();
				wait_drained();
				set_max_payload(7'($urandom_range(4, 70)));
			end
			lim = cur_limit();
			flen = ($urandom_range(0, 99) < 85) ? $urandom_range(0, lim < 8 ? lim : 8)
				: $urandom_range(0, lim);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_frame(8'($urandom), 16'(flen), make_body(flen, 1'b0), 0, 1'b0);
			end else if (r < 78) begin
				send_frame(8'($urandom), 16'(flen), make_body(flen, 1'b0),
					$urandom_range(1, 4), 1'b0);
			end else if (r < 84) begin
				send_frame(8'($urandom), 16'(flen), make_body(flen, 1'b0), 0, 1'b1);
			end else if (r < 88) begin
				flen = ($urandom_range(0, 1) == 0) ? lim + $urandom_range(1, 4)
					: $urandom_range(256, 65535);
				send_frame(8'($urandom), 16'(flen), make_body($urandom_range(0, 6), 1'b0),
					0, 1'b0);
			end else if (r < 92) begin
				send_frame(8'($urandom), 16'(flen + $urandom_range(1, 5)),
					make_body(flen, 1'b0), 0, 1'b0);
			end else if (r < 95) begin
				send_frame(8'($urandom), 16'(flen), make_body(flen, 1'b1), 0, 1'b0);
			end else begin
				repeat ($urandom_range(1, 8)) send_beat(8'($urandom));
			end
			if ($urandom_range(0, 1) == 0) flush_frame();
			if ($urandom_range(0, 99) < 4) wait_drained();
		end
		quiet = 1'b0;
		flush_frame();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_data      = 7'd0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		frame_fill      = 0;
		max_payload_cfg = 7'd64;
		mismatches      = 0;
		beats_sent      = 0;
		quiet           = 1'b0;
		long_stall_req  = 0;
		res_stall_left  = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_limit();
		test_empty_payload();
		test_field_extremes();
		test_bad_frames();
		test_noise();
		test_overflow();
		test_limit_settings();
		test_backpressure();
		test_random();

		wait_drained();
		if (mismatches == 0 && awaited_payload.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== crc8_frame_receiver.f =====
rtl/crcfr_pkg.sv
rtl/crcfr_if.sv
rtl/crcfr_front.sv
rtl/crcfr_fifo.sv
rtl/crcfr_back.sv
rtl/crc8_frame_receiver.sv
tb/tb_crc8_frame_receiver.sv
